// ----- rtl/pse_pkg.sv -----
// pse_pkg: shared types and constants of the prime sieve engine
// depends on nothing; imported by the controller, datapath and top level
package pse_pkg;

  localparam int LIM_W  = 13;   // limit register and effective limit
  localparam int NUM_W  = 12;   // queried number
  localparam int BASE_W = 7;    // sieve base, i*i below the limit keeps i under 91
  localparam int SQ_W   = 14;   // square of the base and the multiple pointer
  localparam int LIM_CAP = 8191;

  localparam logic [LIM_W-1:0]  MIN_LIM    = 13'd3;
  localparam logic [LIM_W-1:0]  LIM_RESET  = 13'd4096;
  localparam logic [BASE_W-1:0] FIRST_BASE = 7'd2;
  localparam logic [SQ_W-1:0]   FIRST_SQ   = 14'd4;

  localparam logic OP_RUN   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic fill_start;
    logic fill_step;
    logic query_start;
    logic base_read;
    logic base_next;
    logic mark_init;
    logic mark_step;
    logic out_load;
  } pse_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic fill_last;
    logic sq_lt_lim;
    logic rd_flag;
    logic j_lt_lim;
    logic out_free;
  } pse_stat_t;

endpackage

// ----- rtl/prime_sieve_engine_unit.sv -----
// prime_sieve_engine_unit: one word at a time; a query passes through the query and done states before out_valid
// a run writes all MAX_NUMBERS flags in the fill pass (one ram write each), then for each base i
// with i*i below the limit reads the flag of i and, for a prime base, clears every multiple from
// i*i on (a composite is cleared once per prime factor up to its root); the single write port of
// the flag ram sets the pace
// synchronous active-low reset: limit back to 4096, output empty, queries read not prime
// until the first run
module prime_sieve_engine_unit #(
  parameter int MAX_NUMBERS = 4096
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [pse_pkg::LIM_W-1:0] cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_op,
  input  logic [pse_pkg::NUM_W-1:0] in_number,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_is_prime,
  output logic                      out_out_of_range
);
  import pse_pkg::*;

  pse_cmd_t  cmd;
  pse_stat_t stat;

  pse_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  pse_dpath #(
    .MAX_NUMBERS (MAX_NUMBERS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_number        (in_number),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_is_prime     (out_is_prime),
    .out_out_of_range (out_out_of_range),
    .cmd              (cmd),
    .stat             (stat)
  );

endmodule

// ----- rtl/pse_ram.sv -----
// pse_ram: generic simple dual-port ram, one write and one registered read port
// depends on nothing
module pse_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/pse_ctrl.sv -----
// pse_ctrl: sequencer of the prime sieve engine (fill, base scan, marking, query)
// depends on pse_pkg
module pse_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_op,
  output logic              in_stall,
  input  pse_pkg::pse_stat_t stat,
  output pse_pkg::pse_cmd_t  cmd
);
  import pse_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FILL  = 7'b0000010,
    S_BASE  = 7'b0000100,
    S_EVAL  = 7'b0001000,
    S_MARK  = 7'b0010000,
    S_QUERY = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_RUN) begin
            cmd.fill_start = 1'b1;
            state_nxt      = S_FILL;
          end else begin
            cmd.query_start = 1'b1;
            state_nxt       = S_QUERY;
          end
        end
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (stat.fill_last) begin
          state_nxt = S_BASE;
        end
      end
      S_BASE: begin
        if (stat.sq_lt_lim) begin
          cmd.base_read = 1'b1;
          state_nxt     = S_EVAL;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_EVAL: begin
        // flag of the base is back from the ram
        if (stat.rd_flag) begin
          cmd.mark_init = 1'b1;
          state_nxt     = S_MARK;
        end else begin
          cmd.base_next = 1'b1;
          state_nxt     = S_BASE;
        end
      end
      S_MARK: begin
        if (stat.j_lt_lim) begin
          cmd.mark_step = 1'b1;
        end else begin
          cmd.base_next = 1'b1;
          state_nxt     = S_BASE;
        end
      end
      S_QUERY: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/pse_dpath.sv -----
// pse_dpath: flag ram, limit register, sieve counters and output register
// depends on pse_pkg and pse_ram
module pse_dpath #(
  parameter int MAX_NUMBERS = 4096
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [pse_pkg::LIM_W-1:0]  cfg_wr_data,
  input  logic [pse_pkg::NUM_W-1:0]  in_number,
  input  logic                       out_stall,
  output logic                       out_valid,
  output logic                       out_is_prime,
  output logic                       out_out_of_range,
  input  pse_pkg::pse_cmd_t          cmd,
  output pse_pkg::pse_stat_t         stat
);
  import pse_pkg::*;

  localparam int AW      = $clog2(MAX_NUMBERS);
  localparam int LIM_MAX = (MAX_NUMBERS > LIM_CAP) ? LIM_CAP : MAX_NUMBERS;
  localparam int CMPW    = (AW > LIM_W) ? AW : LIM_W;

  logic [LIM_W-1:0]  limit_r, limit_nxt;
  logic [LIM_W-1:0]  lim_eff;
  logic [AW-1:0]     ptr_r, ptr_nxt;
  logic [BASE_W-1:0] base_r, base_nxt;
  logic [SQ_W-1:0]   sq_r, sq_nxt;
  logic [SQ_W-1:0]   j_r, j_nxt;
  logic              ran_r, ran_nxt;
  logic              query_r, query_nxt;
  logic              in_range_r, in_range_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_is_prime_r, out_is_prime_nxt;
  logic              out_oor_r, out_oor_nxt;
  logic              fill_val;
  logic              in_range;
  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic              wr_data;
  logic              rd_data;

  always_comb begin
    if (limit_r < MIN_LIM) begin
      lim_eff = MIN_LIM;
    end else if (limit_r > LIM_W'(LIM_MAX)) begin
      lim_eff = LIM_W'(LIM_MAX);
    end else begin
      lim_eff = limit_r;
    end
  end

  // fill pass: numbers from 2 below the limit start marked, all others clear
  assign fill_val = (CMPW'(ptr_r) >= CMPW'(FIRST_BASE)) && (CMPW'(ptr_r) < CMPW'(lim_eff));
  assign in_range = ({1'b0, in_number} < lim_eff);

  assign stat.fill_last = (ptr_r == AW'(MAX_NUMBERS - 1));
  assign stat.sq_lt_lim = (sq_r < SQ_W'(lim_eff));
  assign stat.j_lt_lim  = (j_r < SQ_W'(lim_eff));
  assign stat.rd_flag   = rd_data;
  assign stat.out_free  = !out_valid_r || !out_stall;

  assign wr_en   = cmd.fill_step || cmd.mark_step;
  assign wr_addr = cmd.fill_step ? ptr_r : AW'(j_r);
  assign wr_data = cmd.fill_step && fill_val;
  assign rd_en   = cmd.query_start || cmd.base_read;
  assign rd_addr = cmd.query_start ? AW'(in_number) : AW'(base_r);

  pse_ram #(
    .WIDTH (1),
    .DEPTH (MAX_NUMBERS)
  ) u_flags (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    limit_nxt        = cfg_wr_en ? cfg_wr_data : limit_r;
    ptr_nxt          = ptr_r;
    base_nxt         = base_r;
    sq_nxt           = sq_r;
    j_nxt            = j_r;
    ran_nxt          = ran_r;
    query_nxt        = query_r;
    in_range_nxt     = in_range_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_is_prime_nxt = out_is_prime_r;
    out_oor_nxt      = out_oor_r;

    if (cmd.fill_start) begin
      ptr_nxt   = '0;
      base_nxt  = FIRST_BASE;
      sq_nxt    = FIRST_SQ;
      ran_nxt   = 1'b1;
      query_nxt = 1'b0;
    end
    if (cmd.fill_step) begin
      ptr_nxt = AW'(ptr_r + 1'b1);
    end
    if (cmd.query_start) begin
      query_nxt    = 1'b1;
      in_range_nxt = in_range;
    end
    if (cmd.base_next) begin
      // (i+1)^2 = i^2 + 2i + 1
      sq_nxt   = SQ_W'(sq_r + SQ_W'({base_r, 1'b1}));
      base_nxt = BASE_W'(base_r + 1'b1);
    end
    if (cmd.mark_init) begin
      j_nxt = sq_r;
    end
    if (cmd.mark_step) begin
      j_nxt = SQ_W'(j_r + SQ_W'(base_r));
    end
    if (cmd.out_load) begin
      out_valid_nxt    = 1'b1;
      out_is_prime_nxt = query_r && in_range_r && ran_r && rd_data;
      out_oor_nxt      = query_r && !in_range_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= LIM_RESET;
      ran_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      limit_r     <= limit_nxt;
      ran_r       <= ran_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r          <= ptr_nxt;
    base_r         <= base_nxt;
    sq_r           <= sq_nxt;
    j_r            <= j_nxt;
    query_r        <= query_nxt;
    in_range_r     <= in_range_nxt;
    out_is_prime_r <= out_is_prime_nxt;
    out_oor_r      <= out_oor_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_is_prime     = out_is_prime_r;
  assign out_out_of_range = out_oor_r;

endmodule

// ----- rtl/pse_checker.sv -----
// pse_checker: port-level assertions for prime_sieve_engine_unit
// depends on nothing; bound to the top level below
module pse_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_is_prime,
  input logic out_out_of_range
);

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // a word is never both prime and out of range
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_is_prime && out_out_of_range))
    else $error("is_prime and out_of_range both set");

  // one word at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted back to back");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind prime_sieve_engine_unit pse_checker u_pse_checker (.*);
